// ----- rtl/core/lzwe_pkg.sv -----
// Package for the LZW variable-width encoder.
// Holds sizes, reserved codes and the sequencer state type; no dependencies.
package lzwe_pkg;

    localparam int DICT_ENTRIES   = 4096;
    localparam int MAX_CODE_WIDTH = 12;
    localparam int CODE_BITS      = $clog2(DICT_ENTRIES);
    localparam int WIDTH_BITS     = 4;
    localparam int ENTRY_BITS     = CODE_BITS + 8;

    localparam logic [CODE_BITS-1:0]  CODE_CLEAR  = CODE_BITS'(256);
    localparam logic [CODE_BITS-1:0]  CODE_END    = CODE_BITS'(257);
    localparam logic [CODE_BITS-1:0]  FIRST_FREE  = CODE_BITS'(258);
    localparam logic [CODE_BITS-1:0]  FULL_MARK   = CODE_BITS'(DICT_ENTRIES - 1);
    localparam logic [WIDTH_BITS-1:0] START_WIDTH = WIDTH_BITS'(9);
    localparam logic [WIDTH_BITS-1:0] MAX_WIDTH   = WIDTH_BITS'(MAX_CODE_WIDTH);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_CMP,
        ST_EMIT_P1,
        ST_EMIT_CLR,
        ST_LAST_CHK,
        ST_EMIT_P2,
        ST_EMIT_END
    } state_t;

endpackage

// ----- rtl/core/lzwe_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module lzwe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- rtl/core/lzw_variable_width_encoder_top.sv -----
// Top level of the LZW variable-width encoder: sequencer, state and output register.
// Depends on lzwe_pkg and lzwe_ram.
//
// Usage:
// The slave channel takes one raw byte per request in s_tdata, with s_tlast set on
// the final byte of a stream. The master channel gives one code per request:
// s_tdata-like packing of m_tdata holds the code in bits 11:0 and its width (9..12)
// in bits 15:12; m_tlast marks the end code, the last code of a stream.
// Each byte is looked up by a linear scan of the learned dictionary with one shared
// comparator, each learned entry being read through the registered RAM port and then
// compared. A byte emits up to four codes, and s_tready is high only between bytes.
// A code appears on the master side in the cycle after it is produced; a stalled
// receiver holds the sequencer at its next emit step until the output register frees.
// Reset clears the sequencer, the code counter, the width and the prefix; dictionary
// contents need no clearing, since only entries learned since the last restart are
// ever read. After the end code the block is back in its reset state.
module lzw_variable_width_encoder_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // data_byte[7:0]
    input  logic        s_tlast,   // last_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // code_value[11:0], code_width[15:12]
    output logic        m_tlast    // stream_end
);

    localparam int CB = lzwe_pkg::CODE_BITS;
    localparam int WB = lzwe_pkg::WIDTH_BITS;

    lzwe_pkg::state_t state_reg, state_next;

    logic [CB-1:0] nf_reg, nf_next;
    logic [CB-1:0] prefix_reg, prefix_next;
    logic [WB-1:0] width_reg, width_next;
    logic          pvalid_reg, pvalid_next;
    logic [CB-1:0] idx_reg, idx_next;
    logic [7:0]    ch_reg, ch_next;
    logic          last_reg, last_next;

    logic          ovalid_reg, ovalid_next;
    logic [CB-1:0] ocode_reg, ocode_next;
    logic [WB-1:0] owidth_reg, owidth_next;
    logic          oend_reg, oend_next;

    logic                          out_free;
    logic                          hit;
    logic [CB-1:0]                 idx_inc;
    logic [CB-1:0]                 nf_inc;
    logic [CB:0]                   width_limit;
    logic                          ram_we;
    logic [lzwe_pkg::ENTRY_BITS-1:0] key;
    logic [lzwe_pkg::ENTRY_BITS-1:0] rdata;

    assign out_free    = !ovalid_reg || m_tready;
    assign key         = {prefix_reg, ch_reg};
    assign hit         = (rdata == key);
    assign idx_inc     = idx_reg + CB'(1);
    assign nf_inc      = nf_reg + CB'(1);
    assign width_limit = (CB+1)'(1) << width_reg;
    assign ram_we      = (state_reg == lzwe_pkg::ST_EMIT_P1) && out_free;

    // Dictionary storage.
    lzwe_ram #(
        .WIDTH (lzwe_pkg::ENTRY_BITS),
        .DEPTH (lzwe_pkg::DICT_ENTRIES)
    ) u_dict (
        .clk   (clk),
        .we    (ram_we),
        .waddr (nf_reg),
        .wdata (key),
        .raddr (idx_reg),
        .rdata (rdata)
    );

    // Next-state logic of the sequencer.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            lzwe_pkg::ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    if (!pvalid_reg)
                        state_next = lzwe_pkg::ST_LAST_CHK;
                    else if (nf_reg == lzwe_pkg::FIRST_FREE)
                        state_next = lzwe_pkg::ST_EMIT_P1;
                    else
                        state_next = lzwe_pkg::ST_READ;
                end
            end
            lzwe_pkg::ST_READ:
                state_next = lzwe_pkg::ST_CMP;
            lzwe_pkg::ST_CMP:
            begin
                if (hit)
                    state_next = lzwe_pkg::ST_LAST_CHK;
                else if (idx_inc == nf_reg)
                    state_next = lzwe_pkg::ST_EMIT_P1;
                else
                    state_next = lzwe_pkg::ST_READ;
            end
            lzwe_pkg::ST_EMIT_P1:
            begin
                if (out_free)
                    state_next = (nf_inc >= lzwe_pkg::FULL_MARK) ?
                                 lzwe_pkg::ST_EMIT_CLR : lzwe_pkg::ST_LAST_CHK;
            end
            lzwe_pkg::ST_EMIT_CLR:
            begin
                if (out_free)
                    state_next = lzwe_pkg::ST_LAST_CHK;
            end
            lzwe_pkg::ST_LAST_CHK:
                state_next = last_reg ? lzwe_pkg::ST_EMIT_P2 : lzwe_pkg::ST_IDLE;
            lzwe_pkg::ST_EMIT_P2:
            begin
                if (out_free)
                    state_next = lzwe_pkg::ST_EMIT_END;
            end
            lzwe_pkg::ST_EMIT_END:
            begin
                if (out_free)
                    state_next = lzwe_pkg::ST_IDLE;
            end
            default:
                state_next = lzwe_pkg::ST_IDLE;
        endcase
    end

    // Datapath and output register updates driven by the sequencer.
    always_comb
    begin
        nf_next     = nf_reg;
        prefix_next = prefix_reg;
        width_next  = width_reg;
        pvalid_next = pvalid_reg;
        idx_next    = idx_reg;
        ch_next     = ch_reg;
        last_next   = last_reg;
        ovalid_next = ovalid_reg && !m_tready;
        ocode_next  = ocode_reg;
        owidth_next = owidth_reg;
        oend_next   = oend_reg;
        s_tready    = 1'b0;
        unique case (state_reg)
            lzwe_pkg::ST_IDLE:
            begin
                s_tready  = 1'b1;
                ch_next   = s_tdata;
                last_next = s_tlast;
                idx_next  = lzwe_pkg::FIRST_FREE;
                if (s_tvalid && !pvalid_reg)
                begin
                    prefix_next = CB'(s_tdata);
                    pvalid_next = 1'b1;
                end
            end
            lzwe_pkg::ST_READ:
            begin
            end
            lzwe_pkg::ST_CMP:
            begin
                if (hit)
                    prefix_next = idx_reg;
                idx_next = idx_inc;
            end
            lzwe_pkg::ST_EMIT_P1:
            begin
                if (out_free)
                begin
                    ovalid_next = 1'b1;
                    ocode_next  = prefix_reg;
                    owidth_next = width_reg;
                    oend_next   = 1'b0;
                    nf_next     = nf_inc;
                    if (({1'b0, nf_inc} >= width_limit) && (width_reg < lzwe_pkg::MAX_WIDTH))
                        width_next = width_reg + WB'(1);
                    prefix_next = CB'(ch_reg);
                end
            end
            lzwe_pkg::ST_EMIT_CLR:
            begin
                if (out_free)
                begin
                    ovalid_next = 1'b1;
                    ocode_next  = lzwe_pkg::CODE_CLEAR;
                    owidth_next = width_reg;
                    oend_next   = 1'b0;
                    nf_next     = lzwe_pkg::FIRST_FREE;
                    width_next  = lzwe_pkg::START_WIDTH;
                end
            end
            lzwe_pkg::ST_LAST_CHK:
            begin
            end
            lzwe_pkg::ST_EMIT_P2:
            begin
                if (out_free)
                begin
                    ovalid_next = 1'b1;
                    ocode_next  = prefix_reg;
                    owidth_next = width_reg;
                    oend_next   = 1'b0;
                end
            end
            lzwe_pkg::ST_EMIT_END:
            begin
                if (out_free)
                begin
                    ovalid_next = 1'b1;
                    ocode_next  = lzwe_pkg::CODE_END;
                    owidth_next = width_reg;
                    oend_next   = 1'b1;
                    nf_next     = lzwe_pkg::FIRST_FREE;
                    width_next  = lzwe_pkg::START_WIDTH;
                    prefix_next = '0;
                    pvalid_next = 1'b0;
                end
            end
            default:
            begin
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= lzwe_pkg::ST_IDLE;
            nf_reg     <= lzwe_pkg::FIRST_FREE;
            prefix_reg <= '0;
            width_reg  <= lzwe_pkg::START_WIDTH;
            pvalid_reg <= 1'b0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            nf_reg     <= nf_next;
            prefix_reg <= prefix_next;
            width_reg  <= width_next;
            pvalid_reg <= pvalid_next;
            ovalid_reg <= ovalid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        idx_reg    <= idx_next;
        ch_reg     <= ch_next;
        last_reg   <= last_next;
        ocode_reg  <= ocode_next;
        owidth_reg <= owidth_next;
        oend_reg   <= oend_next;
    end

    assign m_tvalid = ovalid_reg;
    assign m_tdata  = {owidth_reg, ocode_reg};
    assign m_tlast  = oend_reg;

`ifndef SYNTH
    // The code width stays within its legal range.
    a_width_range: assert property (@(posedge clk) disable iff (!rst_n)
        (width_reg >= lzwe_pkg::START_WIDTH) && (width_reg <= lzwe_pkg::MAX_WIDTH))
        else $error("code width out of range");

    // The next free code never drops into the reserved range.
    a_nf_floor: assert property (@(posedge clk) disable iff (!rst_n)
        nf_reg >= lzwe_pkg::FIRST_FREE)
        else $error("next free code below first learned code");

    // Issuing the end code returns the prefix to its empty state.
    a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == lzwe_pkg::ST_EMIT_END) && out_free |=> !pvalid_reg)
        else $error("prefix still valid after end code");

    // The end marker only travels with the end code.
    a_end_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tlast |-> (m_tdata[CB-1:0] == lzwe_pkg::CODE_END))
        else $error("end marker on a code other than end");
`endif

endmodule
